// ===== src/sha512_256_compress_unit_defines.svh =====
// Assertion macros shared by the compression unit.
`ifndef SHA512_256_COMPRESS_UNIT_DEFINES_SVH
`define SHA512_256_COMPRESS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define S512C_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define S512C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/s512c_pkg.sv =====
package s512c_pkg;

	localparam int unsigned WordWidth  = 64;
	localparam int unsigned Rounds     = 80;
	localparam int unsigned BlockWords = 16;

	typedef logic [WordWidth-1:0] word_t;
	typedef logic [7:0][WordWidth-1:0] vars_t;
	typedef logic [3:0] word_cnt_t;
	typedef logic [6:0] round_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL
	} state_t;

	localparam round_t LastRound = round_t'(Rounds - 1);
	localparam word_cnt_t LastWord = word_cnt_t'(BlockWords - 1);

	// SHA-512/256 initial hash, word 0 in element 0.
	localparam vars_t InitHash = {
		64'h0eb72ddc81c52ca2, 64'h2b0199fc2c85b8aa,
		64'hbe5e1e2553863992, 64'h96283ee2a88effe3,
		64'h963877195940eabd, 64'h2393b86b6f53b151,
		64'h9f555fa3c84c64c2, 64'h22312194fc2bf72c
	};

	localparam word_t RoundConst [Rounds] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	// Round constant lookup; indexes past the last round read as zero.
	function automatic word_t round_const(input round_t idx);
		word_t k;
		if (idx < round_t'(Rounds)) begin
			k = RoundConst[idx];
		end else begin
			k = '0;
		end
		return k;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordWidth - n));
	endfunction

	function automatic word_t big_s0(input word_t x);
		return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic word_t big_s1(input word_t x);
		return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic word_t small_s0(input word_t x);
		return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic word_t small_s1(input word_t x);
		return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

endpackage

// ===== src/s512c_round.sv =====
module s512c_round (
	input  s512c_pkg::vars_t cur,
	input  s512c_pkg::word_t hkw,
	output s512c_pkg::vars_t nxt
);
	import s512c_pkg::*;

	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	// One SHA-512 round; hkw already holds h plus the round constant and schedule word.
	always_comb begin
		ch  = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
		maj = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
		t1  = hkw + big_s1(cur[4]) + ch;
		t2  = big_s0(cur[0]) + maj;
		nxt[7] = cur[6];
		nxt[6] = cur[5];
		nxt[5] = cur[4];
		nxt[4] = cur[3] + t1;
		nxt[3] = cur[2];
		nxt[2] = cur[1];
		nxt[1] = cur[0];
		nxt[0] = t1 + t2;
	end

endmodule

// ===== src/sha512_256_compress_unit.sv =====
// Takes one 64-bit message word per cycle while busy is low; 16 words form a block.
// The transfer of a block's 16th word starts 80 rounds, one per cycle on a single
// round unit, followed by the chaining add; busy stays high through both, and done
// strobes for one cycle once the add is done, registered from the final state.
// The receiver cannot stall; each result is presented exactly once.
// Reset (arst_n low, asynchronous) loads the SHA-512/256 initial hash and clears control.
`include "sha512_256_compress_unit_defines.svh"

module sha512_256_compress_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  s512c_pkg::word_t msg_word,
	input  logic             new_message,
	output logic             done,
	output s512c_pkg::word_t hash_word_0,
	output s512c_pkg::word_t hash_word_1,
	output s512c_pkg::word_t hash_word_2,
	output s512c_pkg::word_t hash_word_3,
	output s512c_pkg::word_t hash_word_4,
	output s512c_pkg::word_t hash_word_5,
	output s512c_pkg::word_t hash_word_6,
	output s512c_pkg::word_t hash_word_7
);
	import s512c_pkg::*;

	state_t    state_q;
	state_t    state_d;
	round_t    round_q;
	word_cnt_t word_cnt_q;
	logic      done_q;
	vars_t     chain_q;
	vars_t     vars_q;
	vars_t     vars_nxt;
	word_t     hkw_q;
	word_t     win_q [BlockWords];

	logic      accept;
	logic      last_word;
	logic      round_last;
	word_t     expand_word;

	assign accept     = start && (state_q == ST_IDLE);
	assign last_word  = accept && !new_message && (word_cnt_q == LastWord);
	assign round_last = (round_q == LastRound);
	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;

	// Next schedule word from the 16-word window.
	assign expand_word = small_s1(win_q[14]) + win_q[9] + small_s0(win_q[1]) + win_q[0];

	s512c_round u_round (
		.cur (vars_q),
		.hkw (hkw_q),
		.nxt (vars_nxt)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (last_word) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (round_last) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers and chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			round_q    <= '0;
			word_cnt_q <= '0;
			done_q     <= 1'b0;
			chain_q    <= InitHash;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FINAL);
			if (accept) begin
				if (new_message) begin
					chain_q    <= InitHash;
					word_cnt_q <= word_cnt_t'(1);
				end else if (word_cnt_q == LastWord) begin
					word_cnt_q <= '0;
				end else begin
					word_cnt_q <= word_cnt_q + word_cnt_t'(1);
				end
			end
			if (state_q == ST_ROUND) begin
				round_q <= round_last ? '0 : round_q + round_t'(1);
			end
			if (state_q == ST_FINAL) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + vars_q[i];
				end
			end
		end
	end

	// Schedule window, working variables and the h + K + W precompute.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BlockWords-1] <= msg_word;
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BlockWords-1] <= expand_word;
		end
		if (last_word) begin
			vars_q <= chain_q;
			hkw_q  <= chain_q[7] + round_const('0) + win_q[1];
		end else if (state_q == ST_ROUND) begin
			vars_q <= vars_nxt;
			hkw_q  <= vars_q[6] + round_const(round_q + round_t'(1)) + win_q[1];
		end
	end

	assign hash_word_0 = chain_q[0];
	assign hash_word_1 = chain_q[1];
	assign hash_word_2 = chain_q[2];
	assign hash_word_3 = chain_q[3];
	assign hash_word_4 = chain_q[4];
	assign hash_word_5 = chain_q[5];
	assign hash_word_6 = chain_q[6];
	assign hash_word_7 = chain_q[7];

	`S512C_ASSERT_NEXT(a_final_strobes, clk, arst_n, state_q == ST_FINAL, done_q, "missing result strobe")
	`S512C_ASSERT_SAME(a_done_idle, clk, arst_n, done_q, !busy, "result strobe while busy")
	`S512C_ASSERT_SAME(a_idle_round0, clk, arst_n, state_q == ST_IDLE, round_q == '0, "round count not cleared")
	`S512C_ASSERT_NEXT(a_restart_count, clk, arst_n, accept && new_message, word_cnt_q == word_cnt_t'(1), "restart word miscounted")
	`S512C_ASSERT_NEXT(a_last_round, clk, arst_n, (state_q == ST_ROUND) && round_last, state_q == ST_FINAL, "rounds overran")

endmodule
